// ===== src/qwep_pkg.sv =====
// Package for the quadrature wheel event pacer.
// Holds request/result structs, register codes, pin history patterns and the rate table.
// No dependencies.
package qwep_pkg;

  // Register index codes on the configuration port
  typedef enum logic [2:0] {
    CFG_GAP_TICKS     = 3'd0,
    CFG_HOLD_TICKS    = 3'd1,
    CFG_BEAT_TIMEOUT  = 3'd2,
    CFG_PENDING_LIMIT = 3'd3,
    CFG_USAGE_UP      = 3'd4,
    CFG_USAGE_DOWN    = 3'd5
  } cfg_idx_t;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  // Operation codes of an input request
  typedef enum logic {
    OP_TICK = 1'b0,
    OP_POLL = 1'b1
  } op_t;

  typedef struct packed {
    logic       operation;
    logic [1:0] pins;
  } in_item_t;

  typedef struct packed {
    logic       send_valid;
    logic [9:0] usage_code;
    logic       beating;
    logic [2:0] beat_level_out;
    logic [7:0] beat_rate;
  } out_item_t;

  // Configuration register set
  typedef struct packed {
    logic [7:0]  gap_ticks;
    logic [7:0]  hold_ticks;
    logic [11:0] beat_timeout;
    logic [3:0]  pending_limit;
    logic [9:0]  usage_up;
    logic [9:0]  usage_down;
  } cfg_t;

  // Pin history patterns (three pin pairs) marking a full detent
  localparam logic [5:0] HIST_UP_A   = 6'h0B;
  localparam logic [5:0] HIST_UP_B   = 6'h34;
  localparam logic [5:0] HIST_DOWN_A = 6'h07;
  localparam logic [5:0] HIST_DOWN_B = 6'h38;

  localparam logic [9:0] USAGE_RELEASE = 10'd0;

  // Geometric beat rate per level
  function automatic logic [7:0] beat_rate_lookup(input logic [2:0] level);
    logic [7:0] rate;
    case (level)
      3'd0:    rate = 8'd83;
      3'd1:    rate = 8'd96;
      3'd2:    rate = 8'd111;
      3'd3:    rate = 8'd129;
      3'd4:    rate = 8'd150;
      3'd5:    rate = 8'd174;
      3'd6:    rate = 8'd201;
      default: rate = 8'd233;
    endcase
    return rate;
  endfunction

endpackage

// ===== src/qwep_cfg.sv =====
// Configuration register file of the wheel event pacer.
// Depends on qwep_pkg (cfg_t, cfg_idx_t).
module qwep_cfg import qwep_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                  cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // Register write decode; unknown indexes are dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_GAP_TICKS:     cfg_nxt.gap_ticks     = cfg_wdata[7:0];
        CFG_HOLD_TICKS:    cfg_nxt.hold_ticks    = cfg_wdata[7:0];
        CFG_BEAT_TIMEOUT:  cfg_nxt.beat_timeout  = cfg_wdata[11:0];
        CFG_PENDING_LIMIT: cfg_nxt.pending_limit = cfg_wdata[3:0];
        CFG_USAGE_UP:      cfg_nxt.usage_up      = cfg_wdata[9:0];
        CFG_USAGE_DOWN:    cfg_nxt.usage_down    = cfg_wdata[9:0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gap_ticks     <= 8'd4;
      cfg_r.hold_ticks    <= 8'd12;
      cfg_r.beat_timeout  <= 12'd3570;
      cfg_r.pending_limit <= 4'd8;
      cfg_r.usage_up      <= 10'd233;
      cfg_r.usage_down    <= 10'd234;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== src/qwep_core.sv =====
// Decode and pacing state of the wheel event pacer: applies one request per cycle while go is high.
// Depends on qwep_pkg (in_item_t, out_item_t, cfg_t, history patterns, rate table).
module qwep_core import qwep_pkg::*; #(
  parameter int BEAT_LEVELS = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      go,
  input  in_item_t  item,
  input  cfg_t      cfg,
  output out_item_t result
);

  localparam logic [2:0] LEVEL_TOP   = 3'(BEAT_LEVELS - 1);
  localparam logic [2:0] LEVEL_RESET = (BEAT_LEVELS - 1 < 3) ? 3'(BEAT_LEVELS - 1) : 3'd3;

  logic [1:0]        last_pins_r,   last_pins_nxt;
  logic [5:0]        history_r,     history_nxt;
  logic signed [4:0] queued_r,      queued_nxt;
  logic [7:0]        hold_r,        hold_nxt;
  logic              release_r,     release_nxt;
  logic [2:0]        level_r,       level_nxt;
  logic [11:0]       beat_r,        beat_nxt;

  logic              send;
  logic [9:0]        code;
  logic [5:0]        hist_shift;
  logic              det_up, det_down;
  logic [7:0]        hold_dec;
  logic signed [4:0] lim_pos, lim_neg;

  always_comb begin
    last_pins_nxt = last_pins_r;
    history_nxt   = history_r;
    queued_nxt    = queued_r;
    hold_nxt      = hold_r;
    release_nxt   = release_r;
    level_nxt     = level_r;
    beat_nxt      = beat_r;
    send          = 1'b0;
    code          = USAGE_RELEASE;
    hist_shift    = {history_r[3:0], item.pins};
    det_up        = 1'b0;
    det_down      = 1'b0;
    hold_dec      = hold_r - 8'd1;
    lim_pos       = $signed({1'b0, cfg.pending_limit});
    lim_neg       = -lim_pos;

    if (item.operation == OP_TICK) begin
      // Timers count down
      if (beat_r != 12'd0) beat_nxt = beat_r - 12'd1;
      if (hold_r != 8'd0) begin
        hold_nxt = hold_dec;
        if (hold_dec == cfg.gap_ticks) release_nxt = 1'b1;
      end
      // Pin change shifts history and may complete a detent
      if (item.pins != last_pins_r) begin
        history_nxt   = hist_shift;
        last_pins_nxt = item.pins;
        det_up   = (hist_shift == HIST_UP_A)   || (hist_shift == HIST_UP_B);
        det_down = (hist_shift == HIST_DOWN_A) || (hist_shift == HIST_DOWN_B);
      end
      if (det_up) begin
        if (queued_r < lim_pos) queued_nxt = queued_r + 5'sd1;
        if (level_r < LEVEL_TOP) level_nxt = level_r + 3'd1;
        beat_nxt = cfg.beat_timeout;
      end else if (det_down) begin
        if (queued_r > lim_neg) queued_nxt = queued_r - 5'sd1;
        if (level_r != 3'd0) level_nxt = level_r - 3'd1;
        beat_nxt = cfg.beat_timeout;
      end
    end else if (release_r) begin
      // Poll: a due release goes first
      release_nxt = 1'b0;
      send        = 1'b1;
    end else if (hold_r == 8'd0) begin
      // Poll: pace out one queued detent
      if (queued_r > 5'sd0) begin
        queued_nxt = queued_r - 5'sd1;
        send       = 1'b1;
        code       = cfg.usage_up;
        hold_nxt   = cfg.hold_ticks;
      end else if (queued_r < 5'sd0) begin
        queued_nxt = queued_r + 5'sd1;
        send       = 1'b1;
        code       = cfg.usage_down;
        hold_nxt   = cfg.hold_ticks;
      end
    end
  end

  // Result reflects state after this request
  always_comb begin
    result.send_valid     = send;
    result.usage_code     = code;
    result.beating        = (beat_nxt != 12'd0);
    result.beat_level_out = level_nxt;
    result.beat_rate      = beat_rate_lookup(level_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_pins_r <= 2'd0;
      history_r   <= 6'd0;
      queued_r    <= 5'sd0;
      hold_r      <= 8'd0;
      release_r   <= 1'b0;
      level_r     <= LEVEL_RESET;
      beat_r      <= 12'd0;
    end else if (go) begin
      last_pins_r <= last_pins_nxt;
      history_r   <= history_nxt;
      queued_r    <= queued_nxt;
      hold_r      <= hold_nxt;
      release_r   <= release_nxt;
      level_r     <= level_nxt;
      beat_r      <= beat_nxt;
    end
  end

endmodule

// ===== src/quadrature_wheel_event_pacer_top.sv =====
// Quadrature wheel event pacer: top level with input and result registers.
// Depends on qwep_pkg, qwep_cfg and qwep_core.
//
// Usage:
//   Input channel (in_valid/in_stall/in_data) carries one request: a sample
//   tick with the two encoder pins, or a service poll. Each request yields
//   exactly one result on the output channel (out_valid/out_stall/out_data):
//   an optional press/release report plus the beat indicator fields.
//   Configuration registers go in via cfg_we/cfg_index/cfg_wdata; unknown
//   indexes are ignored; write only with no request in flight (not enforced).
// Path: a request accepted into the input register moves, through the
//   combinational update, into the result register once that register is
//   free, and is taken from there.
// Throughput: one request per cycle unless out_stall holds a waiting result;
//   all state updates settle in one combinational pass between the registers.
// Stall: when out_stall holds a waiting result, one more request is held in
//   the input register and in_stall rises only after that.
// Reset (rst_n low, synchronous): registers return to defaults, the queue,
//   timers and history clear, the beat level goes to 3 (or the top level if
//   fewer levels exist), and both channels are empty.
module quadrature_wheel_event_pacer_top import qwep_pkg::*; #(
  parameter int BEAT_LEVELS = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t      cfg;
  in_item_t  in_item_r;
  logic      in_vld_r, in_vld_nxt;
  out_item_t out_item_r;
  out_item_t result;
  logic      out_vld_r, out_vld_nxt;
  logic      advance;
  logic      in_take;

  qwep_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  qwep_core #(.BEAT_LEVELS(BEAT_LEVELS)) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .go     (advance),
    .item   (in_item_r),
    .cfg    (cfg),
    .result (result)
  );

  // Handshake: request moves on when the result register is empty or being taken
  assign advance  = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = in_vld_r && !advance;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    in_vld_nxt  = in_take ? 1'b1 : (advance ? 1'b0 : in_vld_r);
    out_vld_nxt = advance ? 1'b1 : (out_stall ? out_vld_r : 1'b0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_take) in_item_r <= in_data;
    if (advance) out_item_r <= result;
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_item_r;

  // Checks
  a_no_code_without_send: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.send_valid |-> out_data.usage_code == USAGE_RELEASE)
    else $error("usage code set without a report");

  a_level_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.beat_level_out <= 3'(BEAT_LEVELS - 1))
    else $error("beat level beyond top level");

  a_rate_matches_level: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.beat_rate == beat_rate_lookup(out_data.beat_level_out))
    else $error("beat rate does not match level");

  a_advance_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_vld_r)
    else $error("processed request lost before result register");

endmodule

// ===== bench/quadrature_wheel_event_pacer_top_test.sv =====
// Self-checking bench for quadrature_wheel_event_pacer_top: directed and random requests
// with random idling on both channels, checked against an in-bench predictor.
// Depends on qwep_pkg and the pacer RTL only.
module quadrature_wheel_event_pacer_top_test;
  import qwep_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD    = 20;
  localparam int WHEEL_LEVELS  = 8;
  localparam int PIPE_DEPTH    = 2;
  localparam int RANDOM_ITEMS  = 900;
  localparam int STALL_LIMIT   = 400;
  localparam int PRINT_LIMIT   = 60;

  // Beat level range from the level count, clamped to 2 to 8 levels
  localparam int LEVEL_TOP_INT =
    (WHEEL_LEVELS < 2 ? 2 : (WHEEL_LEVELS > 8 ? 8 : WHEEL_LEVELS)) - 1;
  localparam logic [2:0] LEVEL_TOP   = 3'(LEVEL_TOP_INT);
  localparam logic [2:0] LEVEL_START = 3'(LEVEL_TOP_INT < 3 ? LEVEL_TOP_INT : 3);

  // Indexes past the register list; the block must ignore writes to them
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_B = 3'd7;

  localparam logic [7:0] RATE_BY_LEVEL [8] =
    '{8'd83, 8'd96, 8'd111, 8'd129, 8'd150, 8'd174, 8'd201, 8'd233};

  // Pin pairs in clockwise order; one full turn is two detents
  localparam logic [1:0] WHEEL_GRAY [4] = '{2'd0, 2'd2, 2'd3, 2'd1};

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_item_t              in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_data;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // Predicted block state
  cfg_t              regs;
  logic [1:0]        last_pins;
  logic [5:0]        pin_hist;
  logic signed [4:0] queued;
  logic [7:0]        hold_timer;
  logic              release_due;
  logic [2:0]        level;
  logic [11:0]       beat_timer;

  out_item_t awaited_reports[$];
  logic [1:0] wheel_pos = 2'd0;
  bit  steady_flow = 1'b0;
  int  items_sent = 0;
  int  directed_items = 0;
  int  results_seen = 0;
  int  mismatches = 0;
  int  presses_up = 0;
  int  presses_down = 0;
  int  releases = 0;
  int  reg_writes = 0;
  int  quiet_cycles = 0;

  quadrature_wheel_event_pacer_top #(.BEAT_LEVELS(WHEEL_LEVELS)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Predictor: applies one request to the state copy and returns its report
  function automatic out_item_t pace_wheel(input in_item_t req);
    out_item_t res;
    logic signed [4:0] lim;
    res = '0;
    lim = $signed({1'b0, regs.pending_limit});
    if (req.operation == OP_TICK) begin
      if (beat_timer != '0) beat_timer--;
      if (hold_timer != '0) begin
        hold_timer--;
        if (hold_timer == regs.gap_ticks) release_due = 1'b1;
      end
      if (req.pins != last_pins) begin
        pin_hist  = {pin_hist[3:0], req.pins};
        last_pins = req.pins;
        if (pin_hist == HIST_UP_A || pin_hist == HIST_UP_B) begin
          if (queued < lim) queued++;
          if (level < LEVEL_TOP) level++;
          beat_timer = regs.beat_timeout;
        end else if (pin_hist == HIST_DOWN_A || pin_hist == HIST_DOWN_B) begin
          if (queued > -lim) queued--;
          if (level != '0) level--;
          beat_timer = regs.beat_timeout;
        end
      end
    end else if (release_due) begin
      release_due    = 1'b0;
      res.send_valid = 1'b1;
      res.usage_code = USAGE_RELEASE;
      releases++;
    end else if (hold_timer == '0) begin
      if (queued > 0) begin
        queued--;
        res.send_valid = 1'b1;
        res.usage_code = regs.usage_up;
        hold_timer     = regs.hold_ticks;
        presses_up++;
      end else if (queued < 0) begin
        queued++;
        res.send_valid = 1'b1;
        res.usage_code = regs.usage_down;
        hold_timer     = regs.hold_ticks;
        presses_down++;
      end
    end
    res.beating        = (beat_timer != '0);
    res.beat_level_out = level;
    res.beat_rate      = RATE_BY_LEVEL[level];
    return res;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatches < PRINT_LIMIT) begin
      $display("[%0t] MISMATCH %s on result %0d: got %0d, expected %0d",
               $realtime, what, results_seen, got, want);
    end
    mismatches++;
  endtask

  // Sends one request after a random gap (none in steady flow) and records its predicted report
  task automatic push_request(input in_item_t req);
    int gap;
    gap = steady_flow ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (in_stall !== 1'b0);
    awaited_reports.push_back(pace_wheel(req));
    items_sent++;
  endtask

  task automatic send_tick(input logic [1:0] pins);
    in_item_t req;
    req.operation = OP_TICK;
    req.pins      = pins;
    push_request(req);
    for (int i = 0; i < 4; i++) begin
      if (WHEEL_GRAY[i] == pins) wheel_pos = 2'(i);
    end
  endtask

  // Poll carries random pins, which the block must ignore
  task automatic send_poll();
    in_item_t req;
    req.operation = OP_POLL;
    req.pins      = 2'($urandom_range(0, 3));
    push_request(req);
  endtask

  task automatic spin(input bit clockwise, input int steps);
    for (int i = 0; i < steps; i++) begin
      send_tick(WHEEL_GRAY[clockwise ? wheel_pos + 2'd1 : wheel_pos - 2'd1]);
    end
  endtask

  // Stop sending and wait until every report is back and the pipe is empty
  task automatic settle();
    in_valid <= 1'b0;
    while (awaited_reports.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_GAP_TICKS:     regs.gap_ticks     = value[7:0];
      CFG_HOLD_TICKS:    regs.hold_ticks    = value[7:0];
      CFG_BEAT_TIMEOUT:  regs.beat_timeout  = value[11:0];
      CFG_PENDING_LIMIT: regs.pending_limit = value[3:0];
      CFG_USAGE_UP:      regs.usage_up      = value[9:0];
      CFG_USAGE_DOWN:    regs.usage_down    = value[9:0];
      default: ;
    endcase
    reg_writes++;
  endtask

  task automatic write_all_regs(input int gap, input int hold, input int beat,
                                input int lim, input int up, input int down);
    write_reg(CFG_GAP_TICKS, CFG_DATA_W'(gap));
    write_reg(CFG_HOLD_TICKS, CFG_DATA_W'(hold));
    write_reg(CFG_BEAT_TIMEOUT, CFG_DATA_W'(beat));
    write_reg(CFG_PENDING_LIMIT, CFG_DATA_W'(lim));
    write_reg(CFG_USAGE_UP, CFG_DATA_W'(up));
    write_reg(CFG_USAGE_DOWN, CFG_DATA_W'(down));
  endtask

  // Mostly everyday values, sometimes one of the two extremes
  function automatic int draw_reg(input int top, input int usual_top);
    case ($urandom_range(0, 9))
      0:       return 0;
      1:       return top;
      default: return $urandom_range(0, usual_top);
    endcase
  endfunction

  // Defaults after reset: an idle poll, a clockwise turn, one press
  task automatic test_reset_behavior();
    send_poll();
    spin(1'b1, 4);
    send_poll();
  endtask

  // Queue saturation, then a limit lowered below the queued count
  task automatic test_queue_limits();
    settle();
    write_reg(CFG_PENDING_LIMIT, 12'd2);
    spin(1'b1, 4);
    settle();
    write_reg(CFG_PENDING_LIMIT, 12'd1);
    spin(1'b1, 2);
    spin(1'b0, 2);
  endtask

  // Zero gap, zero hold, zero limit, long beat, then the opposite extremes
  task automatic test_register_extremes();
    settle();
    write_all_regs(0, 0, 4095, 0, 1023, 0);
    write_reg(CFG_IDX_SPARE_A, '1);
    write_reg(CFG_IDX_SPARE_B, '0);
    send_poll();
    spin(1'b0, 4);
    send_tick(WHEEL_GRAY[wheel_pos]);
    send_poll();
    send_poll();
    settle();
    write_all_regs(255, 255, 0, 15, 0, 1023);
    spin(1'b1, 4);
    send_poll();
    send_poll();
    send_poll();
  endtask

  // Phases of random settings; mostly clean turns mixed with polls,
  // plus poll bursts, idle ticks, pin noise and bounces
  task automatic test_random_spinning();
    int first, phase_start, phase_len, hold, n;
    bit dir;
    first = items_sent;
    while (items_sent - first < RANDOM_ITEMS) begin
      settle();
      hold = draw_reg(255, 16);
      write_all_regs(draw_reg(255, hold), hold, draw_reg(4095, 60), draw_reg(15, 6),
                     draw_reg(1023, 1023), draw_reg(1023, 1023));
      if ($urandom_range(0, 2) == 0) begin
        write_reg($urandom_range(0, 1) ? CFG_IDX_SPARE_A : CFG_IDX_SPARE_B,
                  CFG_DATA_W'($urandom_range(0, 4095)));
      end
      steady_flow = ($urandom_range(0, 3) == 0);
      phase_start = items_sent;
      phase_len   = $urandom_range(40, 110);
      while (items_sent - phase_start < phase_len) begin
        case ($urandom_range(0, 9))
          6: begin
            n = $urandom_range(1, 6);
            repeat (n) send_poll();
          end
          7: begin
            n = $urandom_range(1, 10);
            repeat (n) send_tick(WHEEL_GRAY[wheel_pos]);
          end
          8: begin
            n = $urandom_range(1, 4);
            repeat (n) send_tick(2'($urandom_range(0, 3)));
          end
          9: begin
            dir = 1'($urandom_range(0, 1));
            spin(dir, 1);
            spin(!dir, 1);
          end
          default: begin
            dir = 1'($urandom_range(0, 1));
            n   = $urandom_range(1, 12);
            repeat (n) begin
              spin(dir, 1);
              if ($urandom_range(0, 3) == 0) send_tick(WHEEL_GRAY[wheel_pos]);
              if ($urandom_range(0, 2) == 0) send_poll();
            end
          end
        endcase
      end
    end
    steady_flow = 1'b0;
  endtask

  // Result side stall: random hold-off (none in steady flow) before each report is taken
  initial begin : result_stall
    int hold_off;
    do @(posedge clk); while (rst_n !== 1'b1);
    forever begin
      hold_off = steady_flow ? 0 : $urandom_range(0, 11);
      if (hold_off > 0) begin
        out_stall <= 1'b1;
        repeat (hold_off) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
    end
  end

  // Compare each accepted report with the oldest prediction
  always @(posedge clk) begin : report_checker
    out_item_t want;
    if (rst_n === 1'b1 && $isunknown(out_valid)) begin
      report_mismatch("out_valid unknown", 0, 0);
    end else if (rst_n === 1'b1 && out_valid && out_stall === 1'b0) begin
      if (awaited_reports.size() == 0) begin
        report_mismatch("report with nothing outstanding", int'(out_data.usage_code), 0);
      end else begin
        want = awaited_reports.pop_front();
        if (out_data.send_valid !== want.send_valid)
          report_mismatch("send_valid", int'(out_data.send_valid), int'(want.send_valid));
        if (out_data.usage_code !== want.usage_code)
          report_mismatch("usage_code", int'(out_data.usage_code), int'(want.usage_code));
        if (out_data.beating !== want.beating)
          report_mismatch("beating", int'(out_data.beating), int'(want.beating));
        if (out_data.beat_level_out !== want.beat_level_out)
          report_mismatch("beat_level_out", int'(out_data.beat_level_out),
                          int'(want.beat_level_out));
        if (out_data.beat_rate !== want.beat_rate)
          report_mismatch("beat_rate", int'(out_data.beat_rate), int'(want.beat_rate));
      end
      results_seen++;
    end
  end

  // Watchdog: too many cycles with no request, report or register write
  always @(posedge clk) begin
    if (rst_n === 1'b1) begin
      if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall) || cfg_we) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
        $display("Watchdog: no handshake for %0d cycles, %0d reports outstanding",
                 STALL_LIMIT, awaited_reports.size());
        $display("Simulation FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin : main_sequence
    regs.gap_ticks     = 8'd4;
    regs.hold_ticks    = 8'd12;
    regs.beat_timeout  = 12'd3570;
    regs.pending_limit = 4'd8;
    regs.usage_up      = 10'd233;
    regs.usage_down    = 10'd234;
    last_pins   = '0;
    pin_hist    = '0;
    queued      = '0;
    hold_timer  = '0;
    release_due = 1'b0;
    level       = LEVEL_START;
    beat_timer  = '0;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_behavior();
    test_queue_limits();
    test_register_extremes();
    directed_items = items_sent;
    test_random_spinning();
    settle();

    if (awaited_reports.size() != 0) begin
      report_mismatch("reports never delivered", 0, awaited_reports.size());
    end
    $display("Sent %0d requests (%0d directed), checked %0d reports, %0d register writes.",
             items_sent, directed_items, results_seen, reg_writes);
    $display("Reports: %0d up presses, %0d down presses, %0d releases; %0d mismatches.",
             presses_up, presses_down, releases, mismatches);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
